// File: rtl/tpw_pkg.sv
// package for the text pager wrap and pause block
// result kinds, character codes, register indexes, queue entry type
// no dependencies
package tpw_pkg;

    localparam int TAB_STOP_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_PROMPT  = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [7:0] COLUMNS_RST = 8'd80;
    localparam logic [7:0] ROWS_RST    = 8'd24;

    // one entry per byte: slot 0 owed newline, slot 1 main result,
    // slot 2 wrap newline, slot 3 prompt
    typedef struct packed {
        logic [3:0] slot_en;
        logic [1:0] main_kind;
        logic [7:0] ch;
    } t_plan;

endpackage

// File: rtl/tpw_front.sv
// front part: configuration, cursor and credit state, byte classification
// builds one queue entry per byte that gives results; uses tpw_pkg
module tpw_front #(
    parameter int TAB_STOP = tpw_pkg::TAB_STOP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_accept,
    input  logic          i_operation,
    input  logic [7:0]    i_char_in,
    input  logic [7:0]    i_key_count,
    output logic          o_push,
    output tpw_pkg::t_plan o_plan
);

    localparam int PhW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    logic [7:0]     r_columns, n_columns;
    logic [7:0]     r_rows, n_rows;
    logic [7:0]     r_col, n_col;
    logic [PhW-1:0] r_phase, n_phase;
    logic [7:0]     r_row, n_row;
    logic           r_owed, n_owed;
    logic [15:0]    r_credits, n_credits;
    logic           r_paused, n_paused;

    logic [7:0]     cols_eff;
    logic [7:0]     last_row;
    logic [7:0]     row0;
    logic [7:0]     row1;
    logic [7:0]     row2;
    logic [8:0]     col1;
    logic [PhW-1:0] phase1;
    logic [16:0]    cred_sum;
    logic [15:0]    cred_dec;
    logic           wrap;
    tpw_pkg::t_plan plan;
    logic           push;

    assign cols_eff = (r_columns == 8'd0) ? 8'd1 : r_columns;
    assign last_row = ((r_rows < 8'd2) ? 8'd2 : r_rows) - 8'd1;

    always_comb begin
        n_columns = r_columns;
        n_rows    = r_rows;
        n_col     = r_col;
        n_phase   = r_phase;
        n_row     = r_row;
        n_owed    = r_owed;
        n_credits = r_credits;
        n_paused  = r_paused;
        plan      = '0;
        push      = 1'b0;
        row0      = r_owed ? 8'd0 : r_row;
        row1      = row0;
        row2      = row0;
        col1      = {1'b0, r_col};
        phase1    = r_phase;
        wrap      = 1'b0;
        cred_sum  = {1'b0, r_credits} + 17'((i_key_count == 8'd0) ? 8'd1 : i_key_count);
        cred_dec  = (r_credits != 16'd0) ? r_credits - 16'd1 : 16'd0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpw_pkg::CFG_COLUMNS: n_columns = i_cfg_data;
                tpw_pkg::CFG_ROWS:    n_rows    = i_cfg_data;
                default:              n_columns = r_columns;
            endcase
        end

        if (i_accept) begin
            if (i_operation) begin
                n_credits = cred_sum[16] ? 16'hFFFF : cred_sum[15:0];
                n_paused  = 1'b0;
            end else if (r_paused) begin
                plan.slot_en   = 4'b0010;
                plan.main_kind = tpw_pkg::KIND_REFUSED;
                push           = 1'b1;
            end else begin
                plan.slot_en[0] = r_owed;
                plan.ch         = i_char_in;
                n_owed          = 1'b0;
                n_row           = row0;
                if (i_char_in == tpw_pkg::CHAR_LF ||
                    i_char_in == tpw_pkg::CHAR_TAB ||
                    (i_char_in >= tpw_pkg::CHAR_SPACE &&
                     i_char_in <= tpw_pkg::CHAR_TILDE)) begin
                    plan.slot_en[1] = 1'b1;
                    if (i_char_in == tpw_pkg::CHAR_LF) begin
                        plan.main_kind = tpw_pkg::KIND_NEWLINE;
                        row1   = row0 + 8'd1;
                        col1   = 9'd0;
                        phase1 = '0;
                    end else if (i_char_in == tpw_pkg::CHAR_TAB) begin
                        plan.main_kind = tpw_pkg::KIND_CHAR;
                        col1   = {1'b0, r_col} + 9'(TAB_STOP) - 9'(r_phase);
                        phase1 = '0;
                    end else begin
                        plan.main_kind = tpw_pkg::KIND_CHAR;
                        col1   = {1'b0, r_col} + 9'd1;
                        phase1 = (r_phase == PhW'(TAB_STOP - 1)) ? '0 : r_phase + PhW'(1);
                    end
                    wrap = (col1 >= {1'b0, cols_eff});
                    row2 = wrap ? row1 + 8'd1 : row1;
                    plan.slot_en[2] = wrap;
                    n_col   = wrap ? 8'd0 : col1[7:0];
                    n_phase = wrap ? '0 : phase1;
                    n_row   = row2;
                    if (row2 >= last_row) begin
                        plan.slot_en[3] = 1'b1;
                        n_row     = 8'd0;
                        n_col     = 8'd0;
                        n_phase   = '0;
                        n_owed    = 1'b1;
                        n_credits = cred_dec;
                        n_paused  = (cred_dec == 16'd0);
                    end
                end
                push = (plan.slot_en != 4'b0000);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tpw_pkg::COLUMNS_RST;
            r_rows    <= tpw_pkg::ROWS_RST;
            r_col     <= 8'd0;
            r_phase   <= '0;
            r_row     <= 8'd0;
            r_owed    <= 1'b0;
            r_credits <= 16'd1;
            r_paused  <= 1'b0;
        end else begin
            r_columns <= n_columns;
            r_rows    <= n_rows;
            r_col     <= n_col;
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_owed    <= n_owed;
            r_credits <= n_credits;
            r_paused  <= n_paused;
        end
    end

    assign o_push = push;
    assign o_plan = plan;

endmodule

// File: rtl/tpw_queue.sv
// short queue of per-byte result plans between front and back parts
// register based, one write and one read per cycle; uses tpw_pkg
module tpw_queue #(
    parameter int DEPTH = tpw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpw_pkg::t_plan i_plan,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tpw_pkg::t_plan o_plan
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    tpw_pkg::t_plan r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign do_push = i_push && (r_count != CntW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_plan  = r_mem[r_rd_ptr];

endmodule

// File: rtl/tpw_back.sv
// back part: expands one plan into its results, one result per cycle while the
// sink is ready; holds the plan being sent in output registers; uses tpw_pkg
module tpw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_plan_valid,
    input  tpw_pkg::t_plan i_plan,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic [1:0]     o_m_tuser,
    output logic           o_m_tlast
);

    logic [3:0] r_mask, n_mask;
    logic [1:0] r_main_kind, n_main_kind;
    logic [7:0] r_ch, n_ch;
    logic [3:0] rest;
    logic [1:0] kind;
    logic [7:0] ch_out;
    logic       sent;
    logic       load;

    assign rest = r_mask & (r_mask - 4'd1);
    assign sent = (r_mask != 4'd0) && i_m_tready;
    assign load = ((r_mask == 4'd0) || (sent && rest == 4'd0)) && i_plan_valid;

    always_comb begin
        kind   = tpw_pkg::KIND_NEWLINE;
        ch_out = 8'd0;
        if (r_mask[0]) begin
            kind = tpw_pkg::KIND_NEWLINE;
        end else if (r_mask[1]) begin
            kind   = r_main_kind;
            ch_out = (r_main_kind == tpw_pkg::KIND_CHAR) ? r_ch : 8'd0;
        end else if (r_mask[2]) begin
            kind = tpw_pkg::KIND_NEWLINE;
        end else begin
            kind = tpw_pkg::KIND_PROMPT;
        end
    end

    always_comb begin
        n_mask      = sent ? rest : r_mask;
        n_main_kind = r_main_kind;
        n_ch        = r_ch;
        if (load) begin
            n_mask      = i_plan.slot_en;
            n_main_kind = i_plan.main_kind;
            n_ch        = i_plan.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 4'd0;
        end else begin
            r_mask <= n_mask;
        end
        r_main_kind <= n_main_kind;
        r_ch        <= n_ch;
    end

    assign o_pop      = load;
    assign o_m_tvalid = (r_mask != 4'd0);
    assign o_m_tdata  = ch_out;
    assign o_m_tuser  = kind;
    assign o_m_tlast  = (rest == 4'd0);

endmodule

// File: rtl/text_pager_wrap_and_pause_core.sv
// text pager with line wrap and page pause: top level
// a byte's plan goes into the queue, then into the back part's output registers
// throughput: one input item per cycle while the queue has room; one result
// per cycle out of the back part while the output is ready
// reset (i_rst_n low, synchronous): 80 x 24 screen, cursor home, one credit
// uses tpw_pkg, tpw_front, tpw_queue, tpw_back
module text_pager_wrap_and_pause_core #(
    parameter int TAB_STOP    = tpw_pkg::TAB_STOP_DEF,
    parameter int QUEUE_DEPTH = tpw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // char_in [7:0], key_count [15:8]
    input  logic        i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // char_out [7:0]
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast
);

    logic           accept;
    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    tpw_pkg::t_plan plan_in;
    tpw_pkg::t_plan plan_out;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && !full;

    tpw_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_operation (i_s_tuser),
        .i_char_in   (i_s_tdata[7:0]),
        .i_key_count (i_s_tdata[15:8]),
        .o_push      (push),
        .o_plan      (plan_in)
    );

    tpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (plan_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_plan  (plan_out)
    );

    tpw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (q_valid),
        .i_plan       (plan_out),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

    // a refused byte is always a result of its own
    a_refused_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == tpw_pkg::KIND_REFUSED) |-> o_m_tlast)
        else $error("refused result not marked last");

    // only character results carry a byte
    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != tpw_pkg::KIND_CHAR) |-> (o_m_tdata == 8'd0))
        else $error("non-character result carries a byte");

    // a prompt ends the results of its byte
    a_prompt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == tpw_pkg::KIND_PROMPT) |-> o_m_tlast)
        else $error("prompt not marked last");

    // queue never overflows: no push while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("queue written while full");

endmodule

// File: test/tpw_tb_pkg.sv
// shared codes for the text pager testbench
// request operation codes used by the stimulus and the checker
// no dependencies
package tpw_tb_pkg;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_KEYS = 1'b1;

endpackage

// File: test/tpw_result_checker.sv
// checker for the text pager: watches config writes and both stream channels,
// predicts the display results of every request and compares them in order
// uses tpw_pkg and tpw_tb_pkg
module tpw_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // char_in [7:0], key_count [15:8]
    input  logic        i_s_tuser,   // operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // char_out [7:0]
    input  logic [1:0]  i_m_tuser,   // kind
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } t_pager_result;

    logic [7:0]    screen_cols;
    logic [7:0]    screen_rows;
    logic [7:0]    cur_col;
    logic [7:0]    cur_row;
    logic          owe_newline;
    logic          is_paused;
    logic [15:0]   credits;
    t_pager_result exp_fifo [EXP_DEPTH];
    int            exp_head;
    int            exp_tail;
    int            mismatch_count;

    function automatic t_pager_result make_result(logic [1:0] kind, logic [7:0] ch);
        t_pager_result r;
        r.kind = kind;
        r.ch   = ch;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic advance_pager(input logic op, input logic [7:0] ch, input logic [7:0] keys);
        int            eff_cols;
        int            eff_rows;
        int            col;
        int            total;
        int            step_n;
        logic          shown;
        t_pager_result step_buf [4];
        eff_cols = (screen_cols == 8'd0) ? 1 : int'(screen_cols);
        eff_rows = (screen_rows < 8'd2) ? 2 : int'(screen_rows);
        shown = 1'b1;
        step_n = 0;
        if (op == tpw_tb_pkg::OP_KEYS) begin
            total = int'(credits) + ((keys == 8'd0) ? 1 : int'(keys));
            credits = (total > 65535) ? 16'hFFFF : 16'(total);
            is_paused = 1'b0;
            return;
        end
        if (is_paused) begin
            step_buf[step_n] = make_result(tpw_pkg::KIND_REFUSED, 8'h00);
            step_n++;
        end else begin
            if (owe_newline) begin
                step_buf[step_n] = make_result(tpw_pkg::KIND_NEWLINE, 8'h00);
                step_n++;
                owe_newline = 1'b0;
                cur_row = 8'd0;
            end
            col = int'(cur_col);
            if (ch == tpw_pkg::CHAR_LF) begin
                cur_row = cur_row + 8'd1;
                col = 0;
                step_buf[step_n] = make_result(tpw_pkg::KIND_NEWLINE, 8'h00);
                step_n++;
            end else if (ch == tpw_pkg::CHAR_TAB) begin
                col = tpw_pkg::TAB_STOP_DEF *
                      ((col + tpw_pkg::TAB_STOP_DEF) / tpw_pkg::TAB_STOP_DEF);
                step_buf[step_n] = make_result(tpw_pkg::KIND_CHAR, ch);
                step_n++;
            end else if (ch >= tpw_pkg::CHAR_SPACE && ch <= tpw_pkg::CHAR_TILDE) begin
                col = col + 1;
                step_buf[step_n] = make_result(tpw_pkg::KIND_CHAR, ch);
                step_n++;
            end else begin
                shown = 1'b0;
            end
            if (shown) begin
                if (col >= eff_cols) begin
                    col = 0;
                    cur_row = cur_row + 8'd1;
                    step_buf[step_n] = make_result(tpw_pkg::KIND_NEWLINE, 8'h00);
                    step_n++;
                end
                cur_col = 8'(col);
                if (int'(cur_row) >= eff_rows - 1) begin
                    cur_row = 8'd0;
                    cur_col = 8'd0;
                    owe_newline = 1'b1;
                    step_buf[step_n] = make_result(tpw_pkg::KIND_PROMPT, 8'h00);
                    step_n++;
                    if (credits > 16'd0)
                        credits = credits - 16'd1;
                    if (credits == 16'd0)
                        is_paused = 1'b1;
                end
            end
        end
        if (step_n > 0)
            step_buf[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) begin
            exp_fifo[exp_tail % EXP_DEPTH] = step_buf[i];
            exp_tail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pager_result got;
        t_pager_result want;
        if (!i_rst_n) begin
            screen_cols = tpw_pkg::COLUMNS_RST;
            screen_rows = tpw_pkg::ROWS_RST;
            cur_col     = 8'd0;
            cur_row     = 8'd0;
            owe_newline = 1'b0;
            is_paused   = 1'b0;
            credits     = 16'd1;
            exp_head    = 0;
            exp_tail    = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tpw_pkg::CFG_COLUMNS)
                    screen_cols = i_cfg_data;
                else
                    screen_rows = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                advance_pager(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]);
            if (i_m_tvalid && i_m_tready) begin
                got.kind = i_m_tuser;
                got.ch   = i_m_tdata;
                got.last = i_m_tlast;
                if (exp_tail == exp_head) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result kind %0d char %02h last %0d",
                                 $realtime, got.kind, got.ch, got.last);
                end else begin
                    want = exp_fifo[exp_head % EXP_DEPTH];
                    exp_head++;
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch, expected kind %0d char %02h last %0d,",
                                      " got kind %0d char %02h last %0d"},
                                     $realtime, want.kind, want.ch, want.last,
                                     got.kind, got.ch, got.last);
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= exp_tail - exp_head;
    end

    initial begin
        mismatch_count = 0;
        exp_head       = 0;
        exp_tail       = 0;
        o_fail_count   = 0;
        o_pending      = 0;
    end

endmodule

// File: test/testbench.sv
// top of the text pager testbench: clock, reset, stimulus, idling and verdict
// depends on tpw_pkg, tpw_tb_pkg, tpw_result_checker and the pager core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    text_pager_wrap_and_pause_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    tpw_result_checker result_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_request(input logic op, input logic [7:0] ch, input logic [7:0] keys);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {keys, ch};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic text_byte(input logic [7:0] ch);
        push_request(tpw_tb_pkg::OP_TEXT, ch, 8'($urandom_range(128)));
    endtask

    task automatic key_press(input logic [7:0] keys);
        push_request(tpw_tb_pkg::OP_KEYS, 8'($urandom_range(255)), keys);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
        drain();
        repeat (12) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tpw_pkg::CFG_COLUMNS;
        i_cfg_data  <= cols;
        @(negedge i_clk);
        i_cfg_index <= tpw_pkg::CFG_ROWS;
        i_cfg_data  <= rows;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly printable text, with line feeds, tabs, dropped bytes and key presses
    task automatic run_random(input int count, input int drain_at);
        int         pick;
        logic [7:0] ch;
        for (int i = 0; i < count; i++) begin
            if (i == drain_at)
                drain();
            pick = $urandom_range(99);
            if (pick < 10) begin
                key_press((pick < 3) ? 8'($urandom_range(128)) : 8'($urandom_range(2)));
            end else begin
                if (pick < 20)
                    ch = tpw_pkg::CHAR_LF;
                else if (pick < 30)
                    ch = tpw_pkg::CHAR_TAB;
                else if (pick < 38)
                    ch = $urandom_range(1) ? 8'($urandom_range(31))
                                           : 8'($urandom_range(255, 127));
                else
                    ch = 8'($urandom_range(126, 32));
                text_byte(ch);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = tpw_pkg::CFG_COLUMNS;
        i_cfg_data    = 8'd0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 16'd0;
        i_s_tuser     = tpw_tb_pkg::OP_TEXT;
        i_m_tready    = 1'b0;
        stall_cycles  = 0;
        send_idle_pct = 17;
        recv_idle_pct = 69;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tiny screen so that wrap, prompt and pause come quickly
        set_geometry(8'd4, 8'd3);
        text_byte(8'h41);
        text_byte(tpw_pkg::CHAR_SPACE);
        text_byte(tpw_pkg::CHAR_TILDE);
        text_byte(tpw_pkg::CHAR_TAB);
        text_byte(tpw_pkg::CHAR_LF);
        text_byte(8'h42);
        text_byte(8'hFF);
        key_press(8'd0);
        text_byte(8'h1F);
        text_byte(8'h7F);
        text_byte(8'h80);
        text_byte(8'h00);
        key_press(8'd128);
        text_byte(8'h78);
        text_byte(8'h79);
        text_byte(8'h7A);
        text_byte(8'h77);
        text_byte(tpw_pkg::CHAR_LF);
        text_byte(8'h71);
        text_byte(tpw_pkg::CHAR_TAB);
        text_byte(tpw_pkg::CHAR_TAB);

        run_random(25, -1);
        set_geometry(8'd0, 8'd1);
        run_random(25, -1);
        set_geometry(8'd255, 8'd255);
        run_random(25, -1);

        send_idle_pct = 69;
        recv_idle_pct = 17;
        set_geometry(8'd8, 8'd5);
        run_random(30, 15);
        set_geometry(8'd1, 8'd2);
        run_random(30, -1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(tpw_pkg::COLUMNS_RST, tpw_pkg::ROWS_RST);
        run_random(25, -1);
        set_geometry(8'd3, 8'd4);
        run_random(20, -1);

        key_press(8'd128);
        run_random(8, -1);

        drain();
        repeat (12) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tpw_pkg.sv
rtl/tpw_front.sv
rtl/tpw_queue.sv
rtl/tpw_back.sv
rtl/text_pager_wrap_and_pause_core.sv
test/tpw_tb_pkg.sv
test/tpw_result_checker.sv
test/testbench.sv
